/* rtl/dcf_pkg.sv */
package dcf_pkg;

  localparam int FRAME_LEN  = 60;
  localparam int SYNC_POS   = 59;
  localparam int MARK_A_POS = 17;
  localparam int MARK_B_POS = 20;
  localparam int MIN_POS    = 21;
  localparam int MIN_PAR    = 28;
  localparam int HOUR_POS   = 29;
  localparam int HOUR_PAR   = 35;
  localparam int DAY_POS    = 36;
  localparam int WDAY_POS   = 42;
  localparam int MONTH_POS  = 45;
  localparam int YEAR_POS   = 50;
  localparam int DATE_PAR   = 58;

  localparam int MINUTES      = 60;
  localparam int DEC_BASE     = 10;
  localparam int BCD_RECIP    = 205;  // v*205 >> 11 == v/10 for v < 1029
  localparam int BCD_SHIFT    = 11;

  typedef logic [1:0] sym_t;
  typedef sym_t [FRAME_LEN-1:0] frame_t;

  localparam sym_t SYM_ZERO = 2'd0;
  localparam sym_t SYM_ONE  = 2'd1;
  localparam sym_t SYM_SYNC = 2'd2;

  localparam logic [2:0] CFG_YEAR    = 3'd0;
  localparam logic [2:0] CFG_MONTH   = 3'd1;
  localparam logic [2:0] CFG_DAY     = 3'd2;
  localparam logic [2:0] CFG_WDAY    = 3'd3;
  localparam logic [2:0] CFG_HOUR    = 3'd4;
  localparam logic [2:0] CFG_MINUTE  = 3'd5;
  localparam logic [2:0] CFG_SHORT   = 3'd6;
  localparam logic [2:0] CFG_LONG    = 3'd7;

  localparam logic [6:0] YEAR_RST   = 7'd3;
  localparam logic [3:0] MONTH_RST  = 4'd3;
  localparam logic [4:0] DAY_RST    = 5'd3;
  localparam logic [2:0] WDAY_RST   = 3'd3;
  localparam logic [4:0] HOUR_RST   = 5'd13;
  localparam logic [5:0] MINUTE_RST = 6'd34;
  localparam logic [7:0] SHORT_RST  = 8'd92;
  localparam logic [7:0] LONG_RST   = 8'd200;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  // tens digit in [7:4], units in [3:0]
  function automatic logic [7:0] bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  rem;
    prod = 15'(v) * 15'(BCD_RECIP);
    tens = prod[14:BCD_SHIFT];
    rem  = v - 7'(tens) * 7'(DEC_BASE);
    return {tens, rem[3:0]};
  endfunction

  function automatic frame_t build_frame(input logic [5:0] minute, input logic [4:0] hour,
                                         input logic [4:0] day, input logic [2:0] wday,
                                         input logic [3:0] month, input logic [6:0] year);
    frame_t     f;
    logic [7:0] c_min, c_hour, c_day, c_wday, c_month, c_year;
    logic       p_date;
    c_min   = bcd(7'(minute));
    c_hour  = bcd(7'(hour));
    c_day   = bcd(7'(day));
    c_wday  = bcd(7'(wday));
    c_month = bcd(7'(month));
    c_year  = bcd(year);
    p_date  = ^c_day[5:0] ^ ^c_wday[2:0] ^ ^c_month[4:0] ^ ^c_year[7:0];
    for (int i = 0; i < FRAME_LEN; i++) f[i] = SYM_ZERO;
    f[MARK_A_POS] = SYM_ONE;
    f[MARK_B_POS] = SYM_ONE;
    f[SYNC_POS]   = SYM_SYNC;
    for (int i = 0; i < 7; i++) f[MIN_POS+i]   = {1'b0, c_min[i]};
    for (int i = 0; i < 6; i++) f[HOUR_POS+i]  = {1'b0, c_hour[i]};
    for (int i = 0; i < 6; i++) f[DAY_POS+i]   = {1'b0, c_day[i]};
    for (int i = 0; i < 3; i++) f[WDAY_POS+i]  = {1'b0, c_wday[i]};
    for (int i = 0; i < 5; i++) f[MONTH_POS+i] = {1'b0, c_month[i]};
    for (int i = 0; i < 8; i++) f[YEAR_POS+i]  = {1'b0, c_year[i]};
    f[MIN_PAR]  = {1'b0, ^c_min[6:0]};
    f[HOUR_PAR] = {1'b0, ^c_hour[5:0]};
    f[DATE_PAR] = {1'b0, p_date};
    return f;
  endfunction

endpackage

/* rtl/dcf77_time_code_generator.sv */
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_ready   in_second_tick
// out_     output     out_valid/out_ready second_index, symbol_kind, carrier_off_ms, minute_now
// cfg_     input      cfg_we              cfg_index, cfg_wdata
//
// One item per cycle while in_ready is high: a tick steps the ring of symbol cells by one position,
// or reloads it at the frame wrap. The symbol result sits in one output register after the transfer.
// A zero tick is taken and gives no result.
// Synchronous reset loads the ring with the frame of the reset values.
// in_ready drops only while a result waits and out_ready is low.
module dcf77_time_code_generator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_second_tick,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] out_second_index,
  output logic [1:0] out_symbol_kind,
  output logic [7:0] out_carrier_off_ms,
  output logic [5:0] out_minute_now,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  import dcf_pkg::*;

  localparam frame_t FRAME_RST = build_frame(MINUTE_RST, HOUR_RST, DAY_RST, WDAY_RST,
                                             MONTH_RST, YEAR_RST);

  logic [6:0] year_r;
  logic [3:0] month_r;
  logic [4:0] day_r;
  logic [2:0] wday_r;
  logic [4:0] hour_r;
  logic [7:0] short_r;
  logic [7:0] long_r;

  logic [5:0] second_r, second_nxt;
  logic [5:0] minute_r, minute_nxt;
  logic [6:0] minute_inc;
  logic [5:0] minute_wrap;

  logic       out_valid_r;
  logic [5:0] idx_r;
  sym_t       kind_r;
  logic [7:0] off_r;
  logic [5:0] min_out_r;

  logic       tick_go, wrap;
  frame_t     frame_new;
  sym_t       cell_q [FRAME_LEN];
  sym_t       emit_sym;
  logic [7:0] emit_off;
  cell_ctrl_t ctrl;

  assign in_ready = !out_valid_r || out_ready;
  assign tick_go  = in_valid && in_ready && in_second_tick;
  assign wrap     = (second_r == 6'(SYNC_POS));

  assign minute_inc  = 7'(minute_r) + 7'd1;
  assign minute_wrap = (minute_inc >= 7'(MINUTES)) ? 6'd0 : minute_inc[5:0];
  assign frame_new   = build_frame(minute_wrap, hour_r, day_r, wday_r, month_r, year_r);

  assign ctrl.load  = tick_go && wrap;
  assign ctrl.shift = tick_go && !wrap;

  // cell k holds the symbol sent k+1 ticks from now
  for (genvar k = 0; k < FRAME_LEN; k++) begin : g_ring
    localparam int NXT = (k + 1) % FRAME_LEN;
    dcf_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .rst_sym (FRAME_RST[NXT]),
      .nbr_sym (cell_q[NXT]),
      .load_sym(frame_new[NXT]),
      .sym     (cell_q[k])
    );
  end

  assign emit_sym = wrap ? frame_new[0] : cell_q[0];

  always_comb begin
    case (emit_sym)
      SYM_ZERO: emit_off = short_r;
      SYM_ONE:  emit_off = long_r;
      default:  emit_off = 8'd0;
    endcase
  end

  always_comb begin
    second_nxt = second_r;
    minute_nxt = minute_r;
    if (tick_go) begin
      second_nxt = wrap ? 6'd0 : second_r + 6'd1;
      if (wrap) begin
        minute_nxt = minute_wrap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r      <= YEAR_RST;
      month_r     <= MONTH_RST;
      day_r       <= DAY_RST;
      wday_r      <= WDAY_RST;
      hour_r      <= HOUR_RST;
      short_r     <= SHORT_RST;
      long_r      <= LONG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_YEAR:   year_r      <= cfg_wdata[6:0];
        CFG_MONTH:  month_r     <= cfg_wdata[3:0];
        CFG_DAY:    day_r       <= cfg_wdata[4:0];
        CFG_WDAY:   wday_r      <= cfg_wdata[2:0];
        CFG_HOUR:   hour_r      <= cfg_wdata[4:0];
        // minute writes are ignored, and reset always restores the start minute, so a written value never shows
        CFG_MINUTE: ;
        CFG_SHORT:  short_r     <= cfg_wdata;
        CFG_LONG:   long_r      <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // the start minute MINUTE_RST only matters at reset, where it loads minute_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r    <= 6'd0;
      minute_r    <= MINUTE_RST;
      out_valid_r <= 1'b0;
    end else begin
      second_r <= second_nxt;
      minute_r <= minute_nxt;
      if (tick_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      idx_r     <= second_nxt;
      kind_r    <= emit_sym;
      off_r     <= emit_off;
      min_out_r <= minute_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_second_index   = idx_r;
  assign out_symbol_kind    = kind_r;
  assign out_carrier_off_ms = off_r;
  assign out_minute_now     = min_out_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> idx_r < 6'(FRAME_LEN))
    else $error("second index out of frame");

  a_sync_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == SYM_SYNC |-> idx_r == 6'(SYNC_POS) && off_r == 8'd0)
    else $error("sync symbol off its slot");

  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (idx_r == 6'(MARK_A_POS) || idx_r == 6'(MARK_B_POS)) |->
      kind_r == SYM_ONE)
    else $error("fixed marker bit not one");

  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    tick_go && wrap |=> second_r == 6'd0 && minute_r != $past(minute_r))
    else $error("frame wrap did not advance minute");

  a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && idx_r == 6'd0 |-> kind_r == SYM_ZERO && min_out_r < 6'(MINUTES))
    else $error("bad frame start");

endmodule

/* rtl/dcf_cell.sv */
module dcf_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  dcf_pkg::cell_ctrl_t ctrl,
  input  dcf_pkg::sym_t      rst_sym,
  input  dcf_pkg::sym_t      nbr_sym,
  input  dcf_pkg::sym_t      load_sym,
  output dcf_pkg::sym_t      sym
);
  import dcf_pkg::*;

  sym_t sym_r, sym_nxt;

  always_comb begin
    sym_nxt = sym_r;
    if (ctrl.load) begin
      sym_nxt = load_sym;
    end else if (ctrl.shift) begin
      sym_nxt = nbr_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_r <= rst_sym;
    end else begin
      sym_r <= sym_nxt;
    end
  end

  assign sym = sym_r;

endmodule
